@@ hdl/ppmr_pkg.sv @@
// ---------------------------------------------------------------------------
// ppmr_pkg: pulse power meter readout package
// Shared widths, register indexes, reset values and the structs that pass
// between the control stage and the multiply stage.
// ---------------------------------------------------------------------------
package ppmr_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int SCALE_W  = 32;
    localparam int PERIOD_W = 16;
    localparam int TOTAL_W  = 32;
    localparam int VALUE_W  = 48;
    localparam int ENERGY_W = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_POWER_SCALE      = 3'd0;
    localparam t_cfg_idx CFG_CURRENT_SCALE    = 3'd1;
    localparam t_cfg_idx CFG_VOLTAGE_SCALE    = 3'd2;
    localparam t_cfg_idx CFG_ENERGY_SCALE     = 3'd3;
    localparam t_cfg_idx CFG_MODE_PERIOD      = 3'd4;
    localparam t_cfg_idx CFG_START_IN_CURRENT = 3'd5;
    localparam t_cfg_idx CFG_ENERGY_ENABLE    = 3'd6;

    localparam logic [PERIOD_W-1:0] MODE_PERIOD_RST = 16'd6;
    localparam logic                START_CUR_RST   = 1'b1;
    localparam logic                ENERGY_EN_RST   = 1'b1;

    // items swallowed after reset before results start
    localparam logic [1:0] WARMUP_ITEMS = 2'd2;

    typedef struct packed {
        logic [SCALE_W-1:0] power_scale;
        logic [SCALE_W-1:0] current_scale;
        logic [SCALE_W-1:0] voltage_scale;
        logic [SCALE_W-1:0] energy_scale;
    } t_scales;

    typedef struct packed {
        logic aux_valid;
        logic aux_is_current;
        logic select_level;
    } t_s1_flags;

endpackage

@@ hdl/ppmr_in_if.sv @@
// ---------------------------------------------------------------------------
// ppmr_in_if: input channel
// Valid/ready channel carrying the per-interval pulse counts.
// ---------------------------------------------------------------------------
interface ppmr_in_if
    import ppmr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] power_pulses;
    logic [COUNT_BITS-1:0] aux_pulses;

    modport source (output valid, output power_pulses, output aux_pulses, input ready);
    modport sink   (input valid, input power_pulses, input aux_pulses, output ready);
endinterface

@@ hdl/ppmr_out_if.sv @@
// ---------------------------------------------------------------------------
// ppmr_out_if: result channel
// Valid/ready channel carrying power, aux and energy readings.
// ---------------------------------------------------------------------------
interface ppmr_out_if
    import ppmr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  power_value;
    logic [VALUE_W-1:0]  aux_value;
    logic                aux_valid;
    logic                aux_is_current;
    logic [ENERGY_W-1:0] energy_value;
    logic                select_level;

    modport source (
        output valid, output power_value, output aux_value, output aux_valid,
        output aux_is_current, output energy_value, output select_level,
        input ready
    );
    modport sink (
        input valid, input power_value, input aux_value, input aux_valid,
        input aux_is_current, input energy_value, input select_level,
        output ready
    );
endinterface

@@ hdl/ppmr_ctrl.sv @@
// ---------------------------------------------------------------------------
// ppmr_ctrl: configuration registers, interval state and input stage
// Holds the warm-up count, mode tick count, select mode and pulse total,
// updates them per accepted transaction and registers the stage-1 item.
// ---------------------------------------------------------------------------
module ppmr_ctrl
    import ppmr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [SCALE_W-1:0]    i_cfg_data,
    ppmr_in_if.sink               i_in,
    input  logic                  i_s1_take,
    output logic                  o_s1_valid,
    output logic [COUNT_BITS-1:0] o_s1_power,
    output logic [COUNT_BITS-1:0] o_s1_aux,
    output logic [TOTAL_W-1:0]    o_s1_total,
    output t_s1_flags             o_s1_flags,
    output t_scales               o_scales
);

    t_scales             r_scales;
    logic [PERIOD_W-1:0] r_period;
    logic                r_energy_en;

    logic [1:0]          r_warm, n_warm;
    logic [PERIOD_W-1:0] r_tick, n_tick;
    logic                r_sel, n_sel;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_s1_valid, n_s1_valid;

    logic [COUNT_BITS-1:0] r_s1_power;
    logic [COUNT_BITS-1:0] r_s1_aux;
    logic [TOTAL_W-1:0]    r_s1_total;
    t_s1_flags             r_s1_flags;

    logic                w_accept;
    logic                w_warm_done;
    logic [TOTAL_W:0]    w_sum;

    assign i_in.ready  = !r_s1_valid || i_s1_take;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_warm_done = (r_warm >= WARMUP_ITEMS);
    assign w_sum       = {1'b0, r_total} + (TOTAL_W+1)'(i_in.power_pulses);

    always_comb begin
        n_warm     = r_warm;
        n_tick     = r_tick;
        n_sel      = r_sel;
        n_total    = r_total;
        n_s1_valid = i_s1_take ? 1'b0 : r_s1_valid;
        if (w_accept) begin
            if (!w_warm_done) begin
                n_warm = r_warm + 2'd1;
            end else begin
                n_s1_valid = 1'b1;
                if (r_energy_en) begin
                    n_total = w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
                end
                if (r_tick == r_period) begin
                    n_tick = '0;
                    n_sel  = ~r_sel;
                end else begin
                    n_tick = r_tick + PERIOD_W'(1);
                end
            end
        end
        // start mode write lands on the live mode only during warm-up;
        // afterwards it has no effect, and reset restores the default
        if (i_cfg_we && (i_cfg_index == CFG_START_IN_CURRENT) && !w_warm_done) begin
            n_sel = i_cfg_data[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scales    <= '0;
            r_period    <= MODE_PERIOD_RST;
            r_energy_en <= ENERGY_EN_RST;
            r_warm      <= '0;
            r_tick      <= '0;
            r_sel       <= START_CUR_RST;
            r_total     <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            r_warm     <= n_warm;
            r_tick     <= n_tick;
            r_sel      <= n_sel;
            r_total    <= n_total;
            r_s1_valid <= n_s1_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POWER_SCALE:      r_scales.power_scale   <= i_cfg_data;
                    CFG_CURRENT_SCALE:    r_scales.current_scale <= i_cfg_data;
                    CFG_VOLTAGE_SCALE:    r_scales.voltage_scale <= i_cfg_data;
                    CFG_ENERGY_SCALE:     r_scales.energy_scale  <= i_cfg_data;
                    CFG_MODE_PERIOD:      r_period    <= i_cfg_data[PERIOD_W-1:0];
                    CFG_ENERGY_ENABLE:    r_energy_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // stage-1 payload; counts of 0 or 1 read as zero
    always_ff @(posedge i_clk) begin
        if (w_accept && w_warm_done) begin
            r_s1_power <= (i_in.power_pulses > COUNT_BITS'(1)) ? i_in.power_pulses : '0;
            r_s1_aux   <= (i_in.aux_pulses > COUNT_BITS'(1)) ? i_in.aux_pulses : '0;
            r_s1_total <= n_total;
            r_s1_flags.aux_valid      <= (r_tick != '0);
            r_s1_flags.aux_is_current <= r_sel;
            r_s1_flags.select_level   <= n_sel;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_power = r_s1_power;
    assign o_s1_aux   = r_s1_aux;
    assign o_s1_total = r_s1_total;
    assign o_s1_flags = r_s1_flags;
    assign o_scales   = r_scales;

endmodule

@@ hdl/ppmr_mult.sv @@
// ---------------------------------------------------------------------------
// ppmr_mult: scaling multipliers and result register
// Three parallel products from the stage-1 item into the output register.
// ---------------------------------------------------------------------------
module ppmr_mult
    import ppmr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s1_valid,
    input  logic [COUNT_BITS-1:0] i_s1_power,
    input  logic [COUNT_BITS-1:0] i_s1_aux,
    input  logic [TOTAL_W-1:0]    i_s1_total,
    input  t_s1_flags             i_s1_flags,
    input  t_scales               i_scales,
    output logic                  o_s1_take,
    ppmr_out_if.source            o_out
);

    localparam int PROD_W = COUNT_BITS + SCALE_W;

    logic                r_valid;
    logic [VALUE_W-1:0]  r_power;
    logic [VALUE_W-1:0]  r_aux;
    logic [ENERGY_W-1:0] r_energy;
    t_s1_flags           r_flags;

    logic [SCALE_W-1:0]  w_aux_scale;
    logic [PROD_W-1:0]   w_power_prod;
    logic [PROD_W-1:0]   w_aux_prod;
    logic [ENERGY_W-1:0] w_power_ext;
    logic [ENERGY_W-1:0] w_aux_ext;
    logic [ENERGY_W-1:0] w_energy_prod;

    assign w_aux_scale   = i_s1_flags.aux_is_current ? i_scales.current_scale
                                                     : i_scales.voltage_scale;
    assign w_power_prod  = PROD_W'(i_s1_power) * PROD_W'(i_scales.power_scale);
    assign w_aux_prod    = PROD_W'(i_s1_aux) * PROD_W'(w_aux_scale);
    assign w_power_ext   = ENERGY_W'(w_power_prod);
    assign w_aux_ext     = ENERGY_W'(w_aux_prod);
    assign w_energy_prod = ENERGY_W'(i_s1_total) * ENERGY_W'(i_scales.energy_scale);

    assign o_s1_take = i_s1_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s1_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_power  <= w_power_ext[VALUE_W-1:0];
            r_aux    <= i_s1_flags.aux_valid ? w_aux_ext[VALUE_W-1:0] : '0;
            r_energy <= w_energy_prod;
            r_flags  <= i_s1_flags;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.power_value    = r_power;
    assign o_out.aux_value      = r_aux;
    assign o_out.aux_valid      = r_flags.aux_valid;
    assign o_out.aux_is_current = r_flags.aux_is_current;
    assign o_out.energy_value   = r_energy;
    assign o_out.select_level   = r_flags.select_level;

endmodule

@@ hdl/pulse_power_meter_readout_unit.sv @@
// ---------------------------------------------------------------------------
// pulse_power_meter_readout_unit: pulse power meter readout, top level
// Data path: an item is registered in the ppmr_ctrl stage-1 register, then in
// the ppmr_mult result register; one transaction per cycle unless o_out.ready stalls.
// The first two transactions after reset update warm-up only, no result.
// Reset is synchronous active low: state, configuration and valid flags to defaults; payload registers are not reset.
// ---------------------------------------------------------------------------
module pulse_power_meter_readout_unit
    import ppmr_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_idx           i_cfg_index,
    input  logic [SCALE_W-1:0] i_cfg_data,
    ppmr_in_if.sink            i_in,
    ppmr_out_if.source         o_out
);

    logic                  w_s1_valid;
    logic                  w_s1_take;
    logic [COUNT_BITS-1:0] w_s1_power;
    logic [COUNT_BITS-1:0] w_s1_aux;
    logic [TOTAL_W-1:0]    w_s1_total;
    t_s1_flags             w_s1_flags;
    t_scales               w_scales;

    ppmr_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_s1_take   (w_s1_take),
        .o_s1_valid  (w_s1_valid),
        .o_s1_power  (w_s1_power),
        .o_s1_aux    (w_s1_aux),
        .o_s1_total  (w_s1_total),
        .o_s1_flags  (w_s1_flags),
        .o_scales    (w_scales)
    );

    ppmr_mult #(
        .COUNT_BITS (COUNT_BITS)
    ) u_mult (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (w_s1_valid),
        .i_s1_power (w_s1_power),
        .i_s1_aux   (w_s1_aux),
        .i_s1_total (w_s1_total),
        .i_s1_flags (w_s1_flags),
        .i_scales   (w_scales),
        .o_s1_take  (w_s1_take),
        .o_out      (o_out)
    );

`ifndef SYNTH
    a_aux_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.aux_valid) |-> (o_out.aux_value == '0))
        else $error("aux value nonzero while aux not valid");

    a_no_result_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid right after reset");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_valid |-> i_in.ready)
        else $error("input stalled with empty input stage");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_take |=> o_out.valid)
        else $error("stage-1 transaction taken but no result presented");
`endif

endmodule
